// ===== rtl/sbsm_pkg.sv =====
// Package of shared types and constants for the sensor band statistics monitor.
`default_nettype none

package sbsm_pkg;

	// Batch size after which the sum and count stop growing (range 1 to 4096).
	localparam int MAX_SENSORS = 256;

	localparam int ID_W     = 8;
	localparam int PH_W     = 11;
	localparam int BAND_W   = 3;
	localparam int STAT_W   = 2;
	localparam int OUT_W    = 9;
	localparam int CNT_W    = $clog2(MAX_SENSORS + 1);
	localparam int SUM_W    = $clog2(((2 ** PH_W) - 1) * MAX_SENSORS + 1);
	localparam int DIV_W    = CNT_W + PH_W;
	localparam int STEP_W   = $clog2(PH_W);
	// Writes to an index past the last limit register are ignored.
	localparam int CFG_IDX_W = 8;

	localparam logic [OUT_W-1:0] OUTSIDE_MAX = '1;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Limit register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LOW_CRIT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LOW_WARN  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_WARN = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_CRIT = CFG_IDX_W'(3);

	// Limit values after reset, in centi-pH (5.0, 6.0, 9.0 and 10.0 pH).
	localparam logic [PH_W-1:0] LOW_CRIT_RESET  = 11'd500;
	localparam logic [PH_W-1:0] LOW_WARN_RESET  = 11'd600;
	localparam logic [PH_W-1:0] HIGH_WARN_RESET = 11'd900;
	localparam logic [PH_W-1:0] HIGH_CRIT_RESET = 11'd1000;

	// Band codes.
	localparam logic [BAND_W-1:0] BAND_NORMAL    = 3'd0;
	localparam logic [BAND_W-1:0] BAND_LOW_WARN  = 3'd1;
	localparam logic [BAND_W-1:0] BAND_LOW_CRIT  = 3'd2;
	localparam logic [BAND_W-1:0] BAND_HIGH_WARN = 3'd3;
	localparam logic [BAND_W-1:0] BAND_HIGH_CRIT = 3'd4;

	// System status codes.
	localparam logic [STAT_W-1:0] STATUS_NORMAL   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_WARNING  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_CRITICAL = 2'd2;

	// Result kinds.
	localparam logic KIND_BAND    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0] sensor_id;
		logic [PH_W-1:0] ph_value;
		logic            batch_end;
	} item_t;

	typedef struct packed {
		logic              result_kind;
		logic [ID_W-1:0]   reading_id;
		logic [BAND_W-1:0] band;
		logic [PH_W-1:0]   average_ph;
		logic [ID_W-1:0]   lowest_id;
		logic [PH_W-1:0]   lowest_ph;
		logic [ID_W-1:0]   highest_id;
		logic [PH_W-1:0]   highest_ph;
		logic [OUT_W-1:0]  abnormal_count;
		logic [STAT_W-1:0] system_status;
		logic              last_result;
	} result_t;

	// One queue entry: the band of a reading, and on a batch end the batch totals.
	typedef struct packed {
		logic [ID_W-1:0]   sensor_id;
		logic [BAND_W-1:0] band;
		logic              batch_end;
		logic [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]  count;
		logic [ID_W-1:0]   min_id;
		logic [PH_W-1:0]   min_ph;
		logic [ID_W-1:0]   max_id;
		logic [PH_W-1:0]   max_ph;
		logic [OUT_W-1:0]  outside;
		logic [STAT_W-1:0] status;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [PH_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/sbsm_fifo.sv =====
// Short register queue that decouples the classifying front from the result back.
`default_nettype none

module sbsm_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  sbsm_pkg::entry_t     wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output sbsm_pkg::entry_t     rd_data,
	output logic                 empty
);
	import sbsm_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sbsm_front.sv =====
// Front part: limit registers, band classification and running batch statistics.
`default_nettype none

module sbsm_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic [sbsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sbsm_pkg::PH_W-1:0]        cfg_data,
	input  wire logic                             accept,
	input  sbsm_pkg::item_t                       item,
	output sbsm_pkg::entry_t                      entry
);
	import sbsm_pkg::*;

	logic [PH_W-1:0]  low_crit_q, low_warn_q, high_warn_q, high_crit_q;
	logic [SUM_W-1:0] sum_q, sum_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [ID_W-1:0]  min_id_q, min_id_n, max_id_q, max_id_n;
	logic [PH_W-1:0]  min_ph_q, min_ph_n, max_ph_q, max_ph_n;
	logic [OUT_W-1:0] outside_q, outside_n;
	logic             first, abnormal;
	logic [BAND_W-1:0] band;
	logic [STAT_W-1:0] status;

	always_comb begin
		first    = (count_q == '0);
		abnormal = (item.ph_value < low_warn_q) || (item.ph_value > high_warn_q);

		if (item.ph_value < low_crit_q) begin
			band = BAND_LOW_CRIT;
		end else if (item.ph_value < low_warn_q) begin
			band = BAND_LOW_WARN;
		end else if (item.ph_value > high_crit_q) begin
			band = BAND_HIGH_CRIT;
		end else if (item.ph_value > high_warn_q) begin
			band = BAND_HIGH_WARN;
		end else begin
			band = BAND_NORMAL;
		end

		min_ph_n = min_ph_q;
		min_id_n = min_id_q;
		max_ph_n = max_ph_q;
		max_id_n = max_id_q;
		if (first || (item.ph_value < min_ph_q)) begin
			min_ph_n = item.ph_value;
			min_id_n = item.sensor_id;
		end
		if (first || (item.ph_value > max_ph_q)) begin
			max_ph_n = item.ph_value;
			max_id_n = item.sensor_id;
		end

		// Once the batch holds the maximum number of readings the sum and count stop growing.
		if (count_q != CNT_W'(MAX_SENSORS)) begin
			sum_n   = sum_q + SUM_W'(item.ph_value);
			count_n = count_q + 1'b1;
		end else begin
			sum_n   = sum_q;
			count_n = count_q;
		end

		outside_n = outside_q;
		if (abnormal && (outside_q != OUTSIDE_MAX)) begin
			outside_n = outside_q + 1'b1;
		end

		if ((min_ph_n < low_crit_q) || (max_ph_n > high_crit_q)) begin
			status = STATUS_CRITICAL;
		end else if (outside_n != '0) begin
			status = STATUS_WARNING;
		end else begin
			status = STATUS_NORMAL;
		end

		entry.sensor_id = item.sensor_id;
		entry.band      = band;
		entry.batch_end = item.batch_end;
		entry.sum       = sum_n;
		entry.count     = count_n;
		entry.min_id    = min_id_n;
		entry.min_ph    = min_ph_n;
		entry.max_id    = max_id_n;
		entry.max_ph    = max_ph_n;
		entry.outside   = outside_n;
		entry.status    = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_crit_q  <= LOW_CRIT_RESET;
			low_warn_q  <= LOW_WARN_RESET;
			high_warn_q <= HIGH_WARN_RESET;
			high_crit_q <= HIGH_CRIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOW_CRIT:  low_crit_q  <= cfg_data;
				REG_LOW_WARN:  low_warn_q  <= cfg_data;
				REG_HIGH_WARN: high_warn_q <= cfg_data;
				REG_HIGH_CRIT: high_crit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			count_q   <= '0;
			min_id_q  <= '0;
			min_ph_q  <= '0;
			max_id_q  <= '0;
			max_ph_q  <= '0;
			outside_q <= '0;
		end else if (accept) begin
			if (item.batch_end) begin
				sum_q     <= '0;
				count_q   <= '0;
				min_id_q  <= '0;
				min_ph_q  <= '0;
				max_id_q  <= '0;
				max_ph_q  <= '0;
				outside_q <= '0;
			end else begin
				sum_q     <= sum_n;
				count_q   <= count_n;
				min_id_q  <= min_id_n;
				min_ph_q  <= min_ph_n;
				max_id_q  <= max_id_n;
				max_ph_q  <= max_ph_n;
				outside_q <= outside_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sbsm_div.sv =====
// Restoring divider that yields the batch average one quotient bit per cycle.
`default_nettype none

module sbsm_div (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  sbsm_pkg::div_req_t req,
	output sbsm_pkg::div_rsp_t rsp
);
	import sbsm_pkg::*;

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsh_q;
	logic [PH_W-1:0]   quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	// The quotient never exceeds the largest reading, so its top bit starts the search.
	assign fits = (rem_q >= dsh_q);

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIV_W'(req.dividend);
			dsh_q <= DIV_W'(req.divisor) << (PH_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[PH_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				step_q <= STEP_W'(PH_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sbsm_back.sv =====
// Back part: drains the queue into the result register and builds batch summaries.
`default_nettype none

module sbsm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  sbsm_pkg::entry_t   q_data,
	input  wire logic          q_empty,
	output logic               q_rd,
	output sbsm_pkg::div_req_t div_req,
	input  sbsm_pkg::div_rsp_t div_rsp,
	output sbsm_pkg::result_t  result,
	output logic               empty,
	input  wire logic          pop
);
	import sbsm_pkg::*;

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_DIV  = 3'b010,
		ST_SUMM = 3'b100
	} state_t;

	state_t  state_q;
	entry_t  summ_q;
	result_t result_q;
	logic    out_valid_q;
	logic    slot_free;
	logic    load_band, load_summ;
	result_t band_res, summ_res;

	assign slot_free = !out_valid_q || pop;
	assign q_rd      = (state_q == ST_RUN) && !q_empty && slot_free;
	assign load_band = q_rd;
	assign load_summ = slot_free &&
		((state_q == ST_SUMM) || ((state_q == ST_DIV) && div_rsp.done));

	assign div_req.start    = q_rd && q_data.batch_end;
	assign div_req.dividend = q_data.sum;
	assign div_req.divisor  = q_data.count;

	always_comb begin
		band_res             = '0;
		band_res.result_kind = KIND_BAND;
		band_res.reading_id  = q_data.sensor_id;
		band_res.band        = q_data.band;
		band_res.last_result = !q_data.batch_end;

		summ_res                = '0;
		summ_res.result_kind    = KIND_SUMMARY;
		summ_res.average_ph     = div_rsp.quotient;
		summ_res.lowest_id      = summ_q.min_id;
		summ_res.lowest_ph      = summ_q.min_ph;
		summ_res.highest_id     = summ_q.max_id;
		summ_res.highest_ph     = summ_q.max_ph;
		summ_res.abnormal_count = summ_q.outside;
		summ_res.system_status  = summ_q.status;
		summ_res.last_result    = 1'b1;
	end

	assign result = result_q;
	assign empty  = !out_valid_q;

	always_ff @(posedge clk) begin
		if (div_req.start) begin
			summ_q <= q_data;
		end
		if (load_band) begin
			result_q <= band_res;
		end else if (load_summ) begin
			result_q <= summ_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			if (load_band || load_summ) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (div_req.start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= load_summ ? ST_RUN : ST_SUMM;
					end
				end
				ST_SUMM: begin
					if (load_summ) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sensor_band_statistics_monitor.sv =====
// Top level of the sensor band statistics monitor: front, queue, back and divider.
// A band result passes through the queue and then the result register to the result ports.
// Readings: one per cycle while the queue is not full; a batch end adds a summary after the
// division, which follows that reading's band result, and meanwhile the queue takes
// readings only until its four entries are full.
// The division unit works one quotient bit per cycle and is the pacing element for summaries.
// Reset: asynchronous, active low; limits return to 500/600/900/1000 centi-pH, statistics clear.
`default_nettype none

module sensor_band_statistics_monitor (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  sbsm_pkg::item_t                     item,
	output logic                                empty,
	input  wire logic                           pop,
	output sbsm_pkg::result_t                   result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sbsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sbsm_pkg::PH_W-1:0]      cfg_data
);
	import sbsm_pkg::*;

	entry_t   fe_entry;
	entry_t   q_data;
	logic     q_empty;
	logic     q_rd;
	logic     accept;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Limit writes are always taken; users must issue them only while the block is idle.
	assign cfg_ready = 1'b1;

	// A reading is a transaction whenever the queue between front and back has room.
	assign accept = push && !full;

	// The front classifies the reading and folds it into the running statistics in the
	// cycle it arrives, and on a batch end it also hands over the finished batch totals.
	sbsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.entry     (fe_entry)
	);

	// The queue lets the front run on while the back waits for a pop or a division.
	sbsm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (fe_entry),
		.full    (full),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// The back emits each band result and, after a batch end, the summary transaction.
	sbsm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

	// The divider forms the truncated average of the batch.
	sbsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

// ===== test/sensor_band_statistics_monitor_checker.sv =====
// Checker for the sensor band statistics monitor: predicts every result and compares it.
`timescale 1ns / 100ps

module sensor_band_statistics_monitor_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic                           full,
	input  sbsm_pkg::item_t                     item,
	input  wire logic                           empty,
	input  wire logic                           pop,
	input  sbsm_pkg::result_t                   result,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [sbsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sbsm_pkg::PH_W-1:0]      cfg_data,
	output int                                  failures,
	output int                                  pending
);
	import sbsm_pkg::*;

	logic [PH_W-1:0]  low_crit;
	logic [PH_W-1:0]  low_warn;
	logic [PH_W-1:0]  high_warn;
	logic [PH_W-1:0]  high_crit;
	logic [SUM_W-1:0] batch_sum;
	logic [CNT_W-1:0] batch_count;
	logic [PH_W-1:0]  low_ph;
	logic [ID_W-1:0]  low_id;
	logic [PH_W-1:0]  high_ph;
	logic [ID_W-1:0]  high_id;
	logic [OUT_W-1:0] outside_total;
	result_t          awaited_results[$];

	initial begin
		failures = 0;
		pending  = 0;
	end

	// The first test that holds wins, whatever order the limits are in.
	function automatic logic [BAND_W-1:0] band_of(input logic [PH_W-1:0] ph);
		if (ph < low_crit) return BAND_LOW_CRIT;
		if (ph < low_warn) return BAND_LOW_WARN;
		if (ph > high_crit) return BAND_HIGH_CRIT;
		if (ph > high_warn) return BAND_HIGH_WARN;
		return BAND_NORMAL;
	endfunction

	task automatic compare(input string field, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", field, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : predict
		result_t band_res;
		result_t summary_res;
		result_t want;
		if (!arst_n) begin
			low_crit      = LOW_CRIT_RESET;
			low_warn      = LOW_WARN_RESET;
			high_warn     = HIGH_WARN_RESET;
			high_crit     = HIGH_CRIT_RESET;
			batch_sum     = '0;
			batch_count   = '0;
			low_ph        = '0;
			low_id        = '0;
			high_ph       = '0;
			high_id       = '0;
			outside_total = '0;
			awaited_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOW_CRIT:  low_crit  = cfg_data;
					REG_LOW_WARN:  low_warn  = cfg_data;
					REG_HIGH_WARN: high_warn = cfg_data;
					REG_HIGH_CRIT: high_crit = cfg_data;
					default: ;
				endcase
			end

			// A result cannot belong to a reading taken at this same edge, so check first.
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					$error("result taken with none awaited");
					failures++;
				end else begin
					want = awaited_results.pop_front();
					compare("result_kind", want.result_kind, result.result_kind);
					compare("reading_id", want.reading_id, result.reading_id);
					compare("band", want.band, result.band);
					compare("average_ph", want.average_ph, result.average_ph);
					compare("lowest_id", want.lowest_id, result.lowest_id);
					compare("lowest_ph", want.lowest_ph, result.lowest_ph);
					compare("highest_id", want.highest_id, result.highest_id);
					compare("highest_ph", want.highest_ph, result.highest_ph);
					compare("abnormal_count", want.abnormal_count, result.abnormal_count);
					compare("system_status", want.system_status, result.system_status);
					compare("last_result", want.last_result, result.last_result);
				end
			end

			if (push && !full) begin
				if (batch_count == 0) begin
					low_ph  = item.ph_value;
					low_id  = item.sensor_id;
					high_ph = item.ph_value;
					high_id = item.sensor_id;
				end else begin
					if (item.ph_value < low_ph) begin
						low_ph = item.ph_value;
						low_id = item.sensor_id;
					end
					if (item.ph_value > high_ph) begin
						high_ph = item.ph_value;
						high_id = item.sensor_id;
					end
				end
				if (batch_count < MAX_SENSORS) begin
					batch_sum   = batch_sum + item.ph_value;
					batch_count = batch_count + 1'b1;
				end
				if ((item.ph_value < low_warn || item.ph_value > high_warn) &&
						outside_total != OUTSIDE_MAX)
					outside_total = outside_total + 1'b1;

				band_res             = '0;
				band_res.result_kind = KIND_BAND;
				band_res.reading_id  = item.sensor_id;
				band_res.band        = band_of(item.ph_value);
				band_res.last_result = !item.batch_end;
				awaited_results.push_back(band_res);

				if (item.batch_end) begin
					summary_res                = '0;
					summary_res.result_kind    = KIND_SUMMARY;
					summary_res.average_ph     = PH_W'(batch_sum / batch_count);
					summary_res.lowest_id      = low_id;
					summary_res.lowest_ph      = low_ph;
					summary_res.highest_id     = high_id;
					summary_res.highest_ph     = high_ph;
					summary_res.abnormal_count = outside_total;
					if (low_ph < low_crit || high_ph > high_crit)
						summary_res.system_status = STATUS_CRITICAL;
					else if (outside_total != 0)
						summary_res.system_status = STATUS_WARNING;
					else
						summary_res.system_status = STATUS_NORMAL;
					summary_res.last_result    = 1'b1;
					awaited_results.push_back(summary_res);

					batch_sum     = '0;
					batch_count   = '0;
					low_ph        = '0;
					low_id        = '0;
					high_ph       = '0;
					high_id       = '0;
					outside_total = '0;
				end
			end
		end
		pending = awaited_results.size();
	end

endmodule

// ===== test/sensor_band_statistics_monitor_test.sv =====
// Top of the sensor band statistics monitor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sensor_band_statistics_monitor_test;
	import sbsm_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	item_t                item;
	logic                 empty;
	logic                 pop;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PH_W-1:0]      cfg_data;

	int failures;
	int pending;

	// The limits as last written, kept only to aim readings at the band edges.
	logic [PH_W-1:0] limit_now [4];

	// Largest gap each side may draw; zero gives a stretch with no idling at all.
	int sender_idle_max;
	int receiver_idle_max;
	int results_taken;

	sensor_band_statistics_monitor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The checker sees exactly what the block sees and keeps the score on its own.
	sensor_band_statistics_monitor_checker band_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop, several times the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Offers one reading after a random gap and holds it until the block takes it.
	// Entered and left at a falling edge, so push stays high between back-to-back readings.
	task automatic send_reading(input logic [ID_W-1:0] id, input logic [PH_W-1:0] ph,
			input logic last);
		int gap;
		gap = $urandom_range(0, sender_idle_max);
		if (gap != 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		item = '{sensor_id: id, ph_value: ph, batch_end: last};
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// Mostly uniform readings, with a good share at the scale ends and on either side
	// of a limit, where the band decisions change.
	function automatic logic [PH_W-1:0] pick_ph();
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 1400;
			2, 3, 4: begin
				v = int'(limit_now[2'($urandom_range(0, 3))]) + int'($urandom_range(0, 2)) - 1;
				if (v < 0) v = 0;
				if (v > 1400) v = 1400;
			end
			default: v = $urandom_range(0, 1400);
		endcase
		return PH_W'(v);
	endfunction

	// Stops offering and waits until every awaited result has been taken, so that the
	// block is idle.
	task automatic drain();
		push = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] index, input int value);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data  = PH_W'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		limit_now[index[1:0]] = PH_W'(value);
	endtask

	// Limits only change while the block holds no work.
	task automatic set_limits(input int lc, input int lw, input int hw, input int hc);
		drain();
		write_limit(REG_LOW_CRIT, lc);
		write_limit(REG_LOW_WARN, lw);
		write_limit(REG_HIGH_WARN, hw);
		write_limit(REG_HIGH_CRIT, hc);
		cfg_valid = 1'b0;
	endtask

	// Whole batches of random readings; most are short, a few run longer.
	task automatic send_random_items(input int count);
		int left;
		int len;
		int i;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(1, 8);
			if (len > left) len = left;
			sender_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			for (i = 0; i < len; i++)
				send_reading(ID_W'($urandom_range(0, 255)), pick_ph(), i == len - 1);
			left -= len;
		end
	endtask

	// Receiver: pops after a random wait for every result. Every so often it holds off
	// for a long stretch while the sender keeps offering, so the block fills and stalls.
	initial begin : receiver
		int wait_cycles;
		pop               = 1'b0;
		receiver_idle_max = 8;
		results_taken     = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (results_taken % 40 == 0)
				receiver_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			wait_cycles = $urandom_range(0, receiver_idle_max);
			if (wait_cycles != 0) begin
				pop = 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			results_taken++;
			@(negedge clk);
			if (results_taken % 500 == 200) begin
				pop = 1'b0;
				repeat (120) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		int i;
		arst_n          = 1'b0;
		push            = 1'b0;
		item            = '0;
		cfg_valid       = 1'b0;
		cfg_index       = REG_LOW_CRIT;
		cfg_data        = '0;
		sender_idle_max = 8;
		limit_now       = '{LOW_CRIT_RESET, LOW_WARN_RESET, HIGH_WARN_RESET, HIGH_CRIT_RESET};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset limits. The first batch walks both sides of every limit and both scale
		// ends, and repeats the lowest and highest readings later under other ids, so the
		// earliest reading must keep its place in the summary.
		send_reading(8'd0, 11'd0, 1'b0);
		send_reading(8'd255, 11'd1400, 1'b0);
		send_reading(8'd17, 11'd499, 1'b0);
		send_reading(8'd18, 11'd500, 1'b0);
		send_reading(8'd19, 11'd599, 1'b0);
		send_reading(8'd20, 11'd600, 1'b0);
		send_reading(8'd21, 11'd900, 1'b0);
		send_reading(8'd22, 11'd901, 1'b0);
		send_reading(8'd23, 11'd1000, 1'b0);
		send_reading(8'd24, 11'd1001, 1'b0);
		send_reading(8'd25, 11'd0, 1'b0);
		send_reading(8'd26, 11'd1400, 1'b0);
		send_reading(8'd27, 11'd1023, 1'b0);
		send_reading(8'd28, 11'd1024, 1'b1);
		// A batch of one reading, all normal.
		send_reading(8'd255, 11'd750, 1'b1);
		// Abnormal but not critical: the status must come out as a warning.
		send_reading(8'd1, 11'd550, 1'b0);
		send_reading(8'd2, 11'd950, 1'b1);

		// Limits in an odd order: the critical tests come first and so win.
		set_limits(1000, 600, 900, 500);
		send_reading(8'd5, 11'd300, 1'b0);
		send_reading(8'd6, 11'd1200, 1'b0);
		send_reading(8'd7, 11'd550, 1'b1);

		// Random batches under a range of limit settings, extremes included.
		set_limits(0, 0, 0, 0);
		send_random_items(25);
		set_limits(1400, 1400, 1400, 1400);
		send_random_items(25);
		set_limits(1000, 600, 900, 500);
		send_random_items(25);
		begin : sorted_limits
			int lc;
			int lw;
			int hw;
			lc = $urandom_range(0, 350);
			lw = $urandom_range(lc, 700);
			hw = $urandom_range(lw, 1050);
			set_limits(lc, lw, hw, $urandom_range(hw, 1400));
		end
		send_random_items(25);
		set_limits($urandom_range(0, 1400), $urandom_range(0, 1400),
			$urandom_range(0, 1400), $urandom_range(0, 1400));
		send_random_items(25);
		set_limits(0, 0, 1400, 1400);
		send_random_items(25);
		set_limits(500, 600, 900, 1000);
		send_random_items(25);

		// One long batch, every reading outside the warning window and offered without a
		// gap: the sum and count stop at the sensor limit and the abnormal count saturates.
		drain();
		sender_idle_max = 0;
		for (i = 0; i < 520; i++)
			send_reading(ID_W'($urandom_range(0, 255)),
				$urandom_range(0, 1) ? PH_W'($urandom_range(0, 599)) :
					PH_W'($urandom_range(901, 1400)),
				i == 519);
		// The state must have cleared behind it.
		send_random_items(10);

		// Let the last transactions land, then allow for the summary division.
		drain();
		repeat (24) @(negedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
